@@ rtl/core/stereo_feedback_echo_core_macros.svh @@
// Assertion helpers for the stereo echo core checks.
`ifndef STEREO_FEEDBACK_ECHO_CORE_MACROS_SVH
`define STEREO_FEEDBACK_ECHO_CORE_MACROS_SVH

// same-cycle implication
`define SFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfe check failed");

// next-cycle implication
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfe check failed");

`endif

@@ rtl/core/sfe_pkg.sv @@
`timescale 1ns / 1ps

package sfe_pkg;

	localparam int SMP_W      = 16;
	localparam int DLY_W      = 14;
	localparam int FB_W       = 16;
	localparam int WET_W      = 17;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int DELAY_DEPTH_DEF = 16384;
	localparam int Q_DEPTH_DEF     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 8'd3;

	localparam logic [DLY_W-1:0] DELAY_RST = 14'd0;
	localparam logic [FB_W-1:0]  FB_RST    = 16'd19661;
	localparam logic [FB_W-1:0]  FB_MAX    = 16'd62259;
	localparam logic [WET_W-1:0] WET_RST   = 17'd16384;
	localparam logic [WET_W-1:0] WET_MAX   = 17'd65536;

	// product and saturation widths
	localparam int FBP_W = 33;
	localparam int MIX_W = 35;
	localparam int SAT_W = 35;

	localparam logic signed [SAT_W-1:0] SAT_HI = 35'sd32767;
	localparam logic signed [SAT_W-1:0] SAT_LO = -35'sd32768;

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic                    last;
		logic                    byp;
	} smp_t;

	typedef struct packed {
		logic [FB_W-1:0]  fb;
		logic [WET_W-1:0] wet;
	} gain_t;

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > SAT_HI) begin
			r = 16'sh7fff;
		end else if (v < SAT_LO) begin
			r = -16'sh8000;
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sfe_ifs.sv @@
`timescale 1ns / 1ps

interface sfe_in_if import sfe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_in;
	logic signed [SMP_W-1:0] right_in;
	logic                    block_last;

	modport source(output valid, output left_in, output right_in, output block_last,
		input ready);
	modport sink(input valid, input left_in, input right_in, input block_last,
		output ready);
endinterface

interface sfe_out_if import sfe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_out;
	logic signed [SMP_W-1:0] right_out;
	logic                    block_last_out;

	modport source(output valid, output left_out, output right_out, output block_last_out,
		input ready);
	modport sink(input valid, input left_out, input right_out, input block_last_out,
		output ready);
endinterface

interface sfe_cfg_if import sfe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sfe_front.sv @@
`timescale 1ns / 1ps

module sfe_front import sfe_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int ENTRY_W     = 2 * $clog2(DELAY_DEPTH) + $bits(smp_t)
) (
	input  logic               clk,
	input  logic               arst_n,
	sfe_in_if.sink             samples,
	sfe_cfg_if.sink            cfg,
	input  logic               clr_busy,
	output gain_t              gains,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [ENTRY_W-1:0] push_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;
	localparam int DMAX = (DELAY_DEPTH - 1 > 16383) ? 16383 : DELAY_DEPTH - 1;
	localparam logic [DLY_W-1:0] DMAX_V = DLY_W'(DMAX);

	logic [DLY_W-1:0] delay_q;
	logic [FB_W-1:0]  fb_q;
	logic [WET_W-1:0] wet_q;
	logic             byp_q;
	logic [AW-1:0]    wi_q;

	logic [DLY_W-1:0] cfg_dly;
	logic [FB_W-1:0]  cfg_fb;
	logic [WET_W-1:0] cfg_wet;
	logic [CW-1:0]    diff;
	logic [CW-1:0]    rd_full;
	logic [AW-1:0]    rd;
	logic             accept;
	smp_t             smp;

	assign cfg.ready = 1'b1;
	assign cfg_dly   = cfg.data[DLY_W-1:0];
	assign cfg_fb    = cfg.data[FB_W-1:0];
	assign cfg_wet   = cfg.data[WET_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			fb_q    <= FB_RST;
			wet_q   <= WET_RST;
			byp_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELAY: begin
					delay_q <= (cfg_dly > DMAX_V) ? DMAX_V : cfg_dly;
				end
				REG_FEEDBACK: begin
					fb_q <= (cfg_fb > FB_MAX) ? FB_MAX : cfg_fb;
				end
				REG_WET: begin
					wet_q <= (cfg_wet > WET_MAX) ? WET_MAX : cfg_wet;
				end
				REG_BYPASS: begin
					byp_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign gains.fb  = fb_q;
	assign gains.wet = wet_q;

	// read point trails the write index by the delay, modulo the depth
	assign diff    = CW'(wi_q) - CW'(delay_q);
	assign rd_full = diff[CW-1] ? diff + CW'(DELAY_DEPTH) : diff;
	assign rd      = rd_full[AW-1:0];

	assign samples.ready = push_ready && !clr_busy;
	assign push_valid    = samples.valid && !clr_busy;
	assign accept        = samples.valid && samples.ready;

	assign smp.left  = samples.left_in;
	assign smp.right = samples.right_in;
	assign smp.last  = samples.block_last;
	assign smp.byp   = byp_q;

	assign push_data = {rd, wi_q, smp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= '0;
		end else if (accept && !byp_q) begin
			wi_q <= (wi_q == AW'(DELAY_DEPTH - 1)) ? '0 : wi_q + 1'b1;
		end
	end

endmodule

@@ rtl/core/sfe_fifo.sv @@
`timescale 1ns / 1ps

module sfe_fifo import sfe_pkg::*; #(
	parameter int WIDTH = $bits(smp_t),
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != NW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/sfe_back.sv @@
`timescale 1ns / 1ps

module sfe_back import sfe_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int ENTRY_W     = 2 * $clog2(DELAY_DEPTH) + $bits(smp_t)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gain_t              gains,
	input  logic               q_valid,
	output logic               q_ready,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               clr_busy,
	sfe_out_if.source          results
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int SW = $bits(smp_t);

	// one word per frame position: left in the upper half, right in the lower
	logic [2*SMP_W-1:0] dline_q [DELAY_DEPTH];

	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	smp_t          head_smp;
	logic [AW-1:0] head_wi;
	logic [AW-1:0] head_rd;
	logic          adv;

	logic               valid_s1;
	smp_t               smp_s1;
	logic [AW-1:0]      rd_s1;
	logic [AW-1:0]      wi_s1;
	logic [2*SMP_W-1:0] rdata_s1;

	logic               valid_s2;
	smp_t               smp_s2;
	logic [AW-1:0]      wi_s2;
	logic signed [FBP_W-1:0] fbp_l_s2, fbp_r_s2;
	logic signed [MIX_W-1:0] dry_l_s2, dry_r_s2, wetp_l_s2, wetp_r_s2;

	logic               hold_v_q;
	logic [AW-1:0]      hold_addr_q;
	logic [2*SMP_W-1:0] hold_data_q;

	logic                    fwd_s2, fwd_hold;
	logic [2*SMP_W-1:0]      dly_word;
	logic signed [SMP_W-1:0] dl, dr;
	logic signed [17:0]      fbk, wet_s, dry_s;
	logic signed [FBP_W-1:0] fbp_l, fbp_r;
	logic signed [MIX_W-1:0] dryp_l, dryp_r, wetp_l, wetp_r;

	logic signed [FBP_W-1:0] fb_sh_l, fb_sh_r;
	logic signed [MIX_W-1:0] mix_l, mix_r;
	logic signed [SMP_W-1:0] st_l, st_r, mo_l, mo_r;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [2*SMP_W-1:0] mem_wdata;

	logic                    out_valid_q;
	logic signed [SMP_W-1:0] left_q, right_q;
	logic                    last_q;

	assign head_smp = q_data[SW-1:0];
	assign head_wi  = q_data[SW +: AW];
	assign head_rd  = q_data[SW + AW +: AW];

	assign adv      = !out_valid_q || results.ready;
	assign q_ready  = adv && !clr_busy_q;
	assign clr_busy = clr_busy_q;

	// zero the delay lines once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(DELAY_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	assign mem_we    = clr_busy_q || (adv && valid_s2 && !smp_s2.byp);
	assign mem_waddr = clr_busy_q ? clr_idx_q : wi_s2;
	assign mem_wdata = clr_busy_q ? '0 : {st_l, st_r};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dline_q[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rdata_s1 <= dline_q[head_rd];
		end
	end

	// stage 1: read data lands, forward pending writes, multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid && !clr_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1 <= head_smp;
			rd_s1  <= head_rd;
			wi_s1  <= head_wi;
		end
	end

	// write retired on the edge that loaded stage 1; the memory read missed it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (adv) begin
			hold_v_q <= valid_s2 && !smp_s2.byp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_addr_q <= wi_s2;
			hold_data_q <= {st_l, st_r};
		end
	end

	// the frame just ahead wins: it is the newest writer
	assign fwd_s2   = valid_s2 && !smp_s2.byp && (wi_s2 == rd_s1);
	assign fwd_hold = hold_v_q && (hold_addr_q == rd_s1);

	always_comb begin
		if (fwd_s2) begin
			dly_word = {st_l, st_r};
		end else if (fwd_hold) begin
			dly_word = hold_data_q;
		end else begin
			dly_word = rdata_s1;
		end
	end

	assign dl = dly_word[2*SMP_W-1:SMP_W];
	assign dr = dly_word[SMP_W-1:0];

	assign fbk   = $signed({2'b00, gains.fb});
	assign wet_s = $signed({1'b0, gains.wet});
	assign dry_s = $signed({1'b0, WET_MAX - gains.wet});

	assign fbp_l  = FBP_W'(dl) * FBP_W'(fbk);
	assign fbp_r  = FBP_W'(dr) * FBP_W'(fbk);
	assign dryp_l = MIX_W'(smp_s1.left) * MIX_W'(dry_s);
	assign dryp_r = MIX_W'(smp_s1.right) * MIX_W'(dry_s);
	assign wetp_l = MIX_W'(dl) * MIX_W'(wet_s);
	assign wetp_r = MIX_W'(dr) * MIX_W'(wet_s);

	// stage 2: shift, add, saturate, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s2    <= smp_s1;
			wi_s2     <= wi_s1;
			fbp_l_s2  <= fbp_l;
			fbp_r_s2  <= fbp_r;
			dry_l_s2  <= dryp_l;
			dry_r_s2  <= dryp_r;
			wetp_l_s2 <= wetp_l;
			wetp_r_s2 <= wetp_r;
		end
	end

	assign fb_sh_l = fbp_l_s2 >>> 16;
	assign fb_sh_r = fbp_r_s2 >>> 16;
	assign st_l    = sat16(SAT_W'(smp_s2.left) + SAT_W'(fb_sh_l));
	assign st_r    = sat16(SAT_W'(smp_s2.right) + SAT_W'(fb_sh_r));

	assign mix_l = (dry_l_s2 + wetp_l_s2) >>> 16;
	assign mix_r = (dry_r_s2 + wetp_r_s2) >>> 16;
	assign mo_l  = sat16(SAT_W'(mix_l));
	assign mo_r  = sat16(SAT_W'(mix_r));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= smp_s2.byp ? smp_s2.left : mo_l;
			right_q <= smp_s2.byp ? smp_s2.right : mo_r;
			last_q  <= smp_s2.last;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.left_out       = left_q;
	assign results.right_out      = right_q;
	assign results.block_last_out = last_q;

endmodule

@@ rtl/core/stereo_feedback_echo_core.sv @@
`timescale 1ns / 1ps

// Stereo feedback echo. Takes one frame per clock and returns one frame per clock
// while results are taken; an accepted frame passes through the queue, then the
// memory read from the queue head, the multiply stage and the add/saturate into the
// output register. The delay lines sit in one DELAY_DEPTH x 32 memory with one
// write and one read port per cycle; reads that hit a write still in flight are
// forwarded, so any delay runs at full rate. With a delay of one the feedback path
// (saturating add into the gain multiplier) sets the clock limit. After reset a
// clearing pass zeroes every word of the memory, during which samples.ready stays
// low; configuration writes are taken at any time but must only be issued while no
// frame is in flight.
module stereo_feedback_echo_core import sfe_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfe_in_if.sink    samples,
	sfe_out_if.source results,
	sfe_cfg_if.sink   cfg
);

	localparam int ENTRY_W = 2 * $clog2(DELAY_DEPTH) + $bits(smp_t);

	gain_t              gains;
	logic               clr_busy;
	logic               push_valid, push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               q_valid, q_ready;
	logic [ENTRY_W-1:0] q_data;

	sfe_front #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.cfg       (cfg),
		.clr_busy  (clr_busy),
		.gains     (gains),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	sfe_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  (push_data),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	sfe_back #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.gains   (gains),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.clr_busy(clr_busy),
		.results (results)
	);

endmodule

@@ rtl/core/sfe_checker.sv @@
`timescale 1ns / 1ps
`include "stereo_feedback_echo_core_macros.svh"

module sfe_checker import sfe_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SMP_W-1:0] left_out,
	input logic signed [SMP_W-1:0] right_out,
	input logic                    last_out
);

	// queue plus two stages plus output register
	localparam int CAP = QUEUE_DEPTH + 3;
	localparam int PW  = $clog2(CAP + 1) + 1;

	logic [PW-1:0]      pending_q;
	logic               in_acc, out_acc;
	logic [2*SMP_W:0]   out_word;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign out_word = {left_out, right_out, last_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`SFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	`SFE_ASSERT_IMPL(a_no_spurious, clk, arst_n, out_valid, pending_q != '0)
	`SFE_ASSERT_IMPL(a_capacity, clk, arst_n, 1'b1, pending_q <= PW'(CAP))
	`SFE_ASSERT_IMPL(a_full_stall, clk, arst_n, pending_q == PW'(CAP), !in_ready)

endmodule

bind stereo_feedback_echo_core sfe_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_sfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.left_out (results.left_out),
	.right_out(results.right_out),
	.last_out (results.block_last_out)
);
